// ----- rtl/core/sorted_insertion_record_sorter_defines.svh -----
// Assertion macros used by the record sorter datapath.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef SORTED_INSERTION_RECORD_SORTER_DEFINES_SVH
`define SORTED_INSERTION_RECORD_SORTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define SIRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorter check failed");

// Next-cycle implication, checked outside reset.
`define SIRS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorter check failed");

`else

`define SIRS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SIRS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/sirs_pkg.sv -----
// Shared types and constants for the record sorter.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package sirs_pkg;

    localparam int DEPTH = 64;
    localparam int KEY_W = 21;
    localparam int TAG_W = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        record_tag;
        logic                    last;
    } in_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] sorted_key;
        logic [TAG_W-1:0]        sorted_tag;
        logic                    end_of_run;
        logic                    overflow;
    } out_t;

    typedef struct packed {
        logic insert;   // place the incoming record into the cells
        logic drop;     // incoming record is lost, mark overflow
        logic emit;     // move the head cell into the output register
    } cmd_t;

    typedef struct packed {
        logic full;       // every cell is occupied
        logic one_left;   // exactly one entry remains
        logic out_free;   // output register can take a new transfer
    } status_t;

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/sirs_ctrl.sv -----
// Controller for the record sorter: load and emit phases.
// Depends on sirs_pkg; drives the datapath through cmd_t and reads status_t.
`default_nettype none

module sirs_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_last,
    output logic                   s_ready,
    input  wire sirs_pkg::status_t status,
    output sirs_pkg::cmd_t         cmd
);
    import sirs_pkg::*;

    state_t state_reg, state_next;
    logic   accept;

    assign accept = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready    = 1'b1;
                cmd.insert = accept && !status.full;
                cmd.drop   = accept && status.full;
                if (accept && s_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                cmd.emit = status.out_free;
                if (status.out_free && status.one_left) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sirs_datapath.sv -----
// Datapath for the record sorter: compare-and-shift cells, entry count,
// overflow flag and output register. Depends on sirs_pkg and the defines header.
`default_nettype none
`include "sorted_insertion_record_sorter_defines.svh"

module sirs_datapath (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire sirs_pkg::in_t   s_data,
    input  wire sirs_pkg::cmd_t  cmd,
    output sirs_pkg::status_t    status,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output sirs_pkg::out_t       m_data
);
    import sirs_pkg::*;

    logic signed [KEY_W-1:0] key_reg [DEPTH];
    logic [TAG_W-1:0]        tag_reg [DEPTH];
    logic [CNT_W-1:0]        cnt_reg;
    logic                    ovf_reg;
    logic                    out_valid_reg;
    out_t                    out_reg;

    // ge[i]: cell i holds a live entry whose key is not below the new key.
    logic [DEPTH-1:0] ge;
    logic [DEPTH-1:0] take_new;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ge[i] = (cnt_reg > CNT_W'(i)) && (key_reg[i] >= s_data.key);
        end
        for (int i = 0; i < DEPTH; i++) begin
            take_new[i] = (ge[i] || (cnt_reg == CNT_W'(i)))
                          && ((i == 0) || !ge[(i == 0) ? 0 : i - 1]);
        end
    end

    assign status.full     = (cnt_reg == CNT_W'(DEPTH));
    assign status.one_left = (cnt_reg == CNT_W'(1));
    assign status.out_free = !out_valid_reg || m_ready;

    // Cells: insertion shifts the tail up by one; emission shifts toward cell 0.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (cmd.insert) begin
                if (i > 0 && ge[(i == 0) ? 0 : i - 1]) begin
                    key_reg[i] <= key_reg[(i == 0) ? 0 : i - 1];
                    tag_reg[i] <= tag_reg[(i == 0) ? 0 : i - 1];
                end else if (take_new[i]) begin
                    key_reg[i] <= s_data.key;
                    tag_reg[i] <= s_data.record_tag;
                end
            end else if (cmd.emit && i < DEPTH - 1) begin
                key_reg[i] <= key_reg[(i < DEPTH - 1) ? i + 1 : i];
                tag_reg[i] <= tag_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.insert) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else if (cmd.emit) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (cmd.drop) begin
                ovf_reg <= 1'b1;
            end else if (cmd.emit && status.one_left) begin
                ovf_reg <= 1'b0;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_reg.sorted_key <= key_reg[0];
            out_reg.sorted_tag <= tag_reg[0];
            out_reg.end_of_run <= status.one_left;
            out_reg.overflow   <= ovf_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `SIRS_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(DEPTH))
    `SIRS_ASSERT_IMP(a_insert_room, aclk, aresetn, cmd.insert, !status.full)
    `SIRS_ASSERT_IMP(a_emit_nonempty, aclk, aresetn, cmd.emit, cnt_reg != '0)
    `SIRS_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.emit, !out_valid_reg || m_ready)
    `SIRS_ASSERT_NXT(a_run_clears, aclk, aresetn, cmd.emit && status.one_left,
                     cnt_reg == '0 && !ovf_reg)

endmodule

`default_nettype wire

// ----- rtl/core/sorted_insertion_record_sorter.sv -----
// Top level of the record sorter: joins the controller and the datapath.
// Depends on sirs_pkg, sirs_ctrl and sirs_datapath.
//
// Usage: records arrive on the s_ channel (key, record_tag, last) and are kept
// in a row of compare-and-shift cells in ascending key order. A record is
// placed ahead of every stored entry whose key is greater than or equal to its
// own, so among equal keys the newest comes first. Each cell compares its own
// key with the incoming one in parallel, so one record is taken every cycle
// while the block is loading. Once the store holds DEPTH entries, further
// records are dropped and a sticky overflow flag is set.
// A transfer with last set ends the data set. The cells then shift toward the
// head and the sorted entries leave on the m_ channel through an output
// register, one per cycle while m_ready stays high; the first follows once the
// controller has entered its emit phase and the head cell has been registered.
// The final entry carries end_of_run, and every entry of the run carries the
// overflow flag. While the run drains, s_ready stays low. A stall on m_ready
// holds the output register and the cells. After the final entry has entered
// the output register, the store is empty and loading resumes even while that
// entry still waits to be taken.
// Reset (aresetn low, synchronous) empties the store, clears the overflow flag
// and the output valid; no clearing pass is needed.
`default_nettype none

module sorted_insertion_record_sorter (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire sirs_pkg::in_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output sirs_pkg::out_t     m_data
);
    import sirs_pkg::*;

    // Commands from the controller and status back from the datapath.
    cmd_t    cmd;
    status_t status;

    sirs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sirs_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ----- sim/sirs_sort_checker.sv -----
// Scoreboard for the record sorter: watches both channels and predicts the sorted runs.
// Depends on sirs_pkg for the payload types and the store depth.
`timescale 1ns / 1ps

module sirs_sort_checker (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    input  wire logic           s_ready,
    input  wire sirs_pkg::in_t  s_data,
    input  wire logic           m_valid,
    input  wire logic           m_ready,
    input  wire sirs_pkg::out_t m_data,
    output int                  fail_count,
    output int                  pending,
    output int                  entries_checked,
    output int                  overflow_runs
);
    import sirs_pkg::*;

    // Predicted contents of the sorted store, head first.
    logic signed [KEY_W-1:0] held_keys[$];
    logic [TAG_W-1:0]        held_tags[$];
    logic                    dropped = 1'b0;

    // Entries that the block still owes on the output channel.
    out_t sorted_due[$];

    int errors       = 0;
    int checked      = 0;
    int spilled_runs = 0;

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Insert one record ahead of the first entry whose key is not smaller, or drop it
    // if the store is full, and queue the whole run when the record closes its data set.
    task automatic absorb_record(input in_t rec);
        logic signed [KEY_W-1:0] k;
        int                      slot;
        out_t                    e;
        k = rec.key;
        if (held_keys.size() >= DEPTH) begin
            dropped = 1'b1;
        end else begin
            slot = 0;
            while (slot < held_keys.size() && held_keys[slot] < k) begin
                slot++;
            end
            held_keys.insert(slot, k);
            held_tags.insert(slot, rec.record_tag);
        end
        if (rec.last) begin
            if (dropped) begin
                spilled_runs++;
            end
            foreach (held_keys[i]) begin
                e.sorted_key = held_keys[i];
                e.sorted_tag = held_tags[i];
                e.end_of_run = (i == held_keys.size() - 1);
                e.overflow   = dropped;
                sorted_due.push_back(e);
            end
            held_keys.delete();
            held_tags.delete();
            dropped = 1'b0;
        end
    endtask

    task automatic check_entry(input out_t got);
        out_t want;
        if (sorted_due.size() == 0) begin
            report_mismatch($sformatf("entry with no run pending: key %0d tag %0d",
                                      $signed(got.sorted_key), got.sorted_tag));
            return;
        end
        want = sorted_due.pop_front();
        checked++;
        if (got.sorted_key !== want.sorted_key) begin
            report_mismatch($sformatf("sorted_key %0d, expected %0d",
                                      $signed(got.sorted_key), $signed(want.sorted_key)));
        end
        if (got.sorted_tag !== want.sorted_tag) begin
            report_mismatch($sformatf("sorted_tag %0d, expected %0d",
                                      got.sorted_tag, want.sorted_tag));
        end
        if (got.end_of_run !== want.end_of_run) begin
            report_mismatch($sformatf("end_of_run %b, expected %b",
                                      got.end_of_run, want.end_of_run));
        end
        if (got.overflow !== want.overflow) begin
            report_mismatch($sformatf("overflow %b, expected %b",
                                      got.overflow, want.overflow));
        end
    endtask

    // Values are sampled at the edge, before any nonblocking update lands. The
    // output is checked first, since a run can never leave in the cycle that
    // its closing record arrives.
    always @(posedge aclk) begin
        if (!aresetn) begin
            held_keys.delete();
            held_tags.delete();
            dropped = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_entry(m_data);
            end
            if (s_valid && s_ready) begin
                absorb_record(s_data);
            end
        end
        pending         <= sorted_due.size();
        fail_count      <= errors;
        entries_checked <= checked;
        overflow_runs   <= spilled_runs;
    end

endmodule

// ----- sim/sorted_insertion_record_sorter_tb.sv -----
// Testbench top for the record sorter: clock, reset, stimulus and the verdict.
// Depends on sirs_pkg, sorted_insertion_record_sorter and sirs_sort_checker.
`timescale 1ns / 1ps

module sorted_insertion_record_sorter_tb;
    import sirs_pkg::*;

    localparam int TARGET_RECORDS = 410;
    localparam int IDLE_PERCENT   = 22;
    localparam int WATCHDOG_LIMIT = 5000;
    // Sorted entries follow their closing record through the state and output
    // registers, so a short settle time after the last expected entry is plenty.
    localparam int SETTLE_CYCLES  = 20;
    // Records in this window are sent, and entries taken, with no idling at all.
    localparam int STEADY_FIRST   = 120;
    localparam int STEADY_LAST    = 200;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    int fail_count;
    int pending;
    int entries_checked;
    int overflow_runs;

    int records_sent = 0;
    int sets_sent    = 0;
    int idle_cycles  = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sorted_insertion_record_sorter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    sirs_sort_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .entries_checked (entries_checked),
        .overflow_runs   (overflow_runs)
    );

    function automatic logic steady_window();
        return records_sent >= STEADY_FIRST && records_sent < STEADY_LAST;
    endfunction

    // The receiver stalls at random outside the steady window. A stall holds
    // the output register and the cells, so it can land on any drain phase.
    always @(posedge aclk) begin
        m_ready <= steady_window() || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // The watchdog counts cycles in which neither channel completes a transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Keys mix near ties, the full 21-bit range, the corners and the range from
    // -900000 to 900000, so equal keys and extreme orderings both show up often.
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned sel;
        int          v;
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
            v = int'($urandom_range(0, 6)) - 3;
        end else if (sel == 2) begin
            v = int'($urandom());
        end else if (sel == 3) begin
            case ($urandom_range(0, 3))
                0:       v = -900000;
                1:       v = 900000;
                2:       v = -(1 << (KEY_W - 1));
                default: v = (1 << (KEY_W - 1)) - 1;
            endcase
        end else begin
            v = int'($urandom_range(0, 1800000)) - 900000;
        end
        return v[KEY_W-1:0];
    endfunction

    // One record transfer. Valid stays high with a steady payload until the
    // block takes it; an idle gap, if any, is inserted before valid rises.
    task automatic send_record(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                               input logic last);
        in_t rec;
        rec.key        = key;
        rec.record_tag = tag;
        rec.last       = last;
        if (!steady_window() && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= rec;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        records_sent++;
        if (last) begin
            sets_sent++;
        end
    endtask

    task automatic send_random_set(input int count);
        for (int i = 0; i < count; i++) begin
            send_record(pick_key(), TAG_W'($urandom_range(0, 65535)), i == count - 1);
        end
    endtask

    initial begin
        int count;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A data set of a single record: the largest 21-bit key, all-ones tag.
        send_record(21'sh0FFFFF, 16'hFFFF, 1'b1);

        // Corners of the key field, zero, minus one, and three equal keys whose
        // tags must come out newest first.
        send_record(21'sd0, 16'h0000, 1'b0);
        send_record(21'sh100000, 16'h0001, 1'b0);
        send_record(21'sd900000, 16'h0002, 1'b0);
        send_record(-21'sd900000, 16'h0003, 1'b0);
        send_record(21'sd100, 16'h0004, 1'b0);
        send_record(21'sd100, 16'h0005, 1'b0);
        send_record(-21'sd1, 16'h0006, 1'b0);
        send_record(21'sd100, 16'h0007, 1'b0);
        send_record(21'sh0FFFFF, 16'hAAAA, 1'b1);

        // Strictly descending keys, each landing at the head, then ascending
        // keys, each landing at the tail.
        for (int i = 0; i < 5; i++) begin
            send_record(KEY_W'(500 - 100 * i), TAG_W'(16'h5500 + i), i == 4);
        end
        for (int i = 0; i < 5; i++) begin
            send_record(KEY_W'(-500 + 100 * i), TAG_W'(16'h5A00 + i), i == 4);
        end

        // The store first fills so that the closing record itself is dropped,
        // then fills exactly, then random sets follow: mostly short, some long,
        // and now and then full or overflowing by several records.
        send_random_set(DEPTH + 1);
        send_random_set(DEPTH);
        while (records_sent < TARGET_RECORDS) begin
            case ($urandom_range(0, 24))
                0:       count = DEPTH + $urandom_range(2, 6);
                1:       count = DEPTH;
                2:       count = $urandom_range(20, 40);
                default: count = $urandom_range(1, 12);
            endcase
            send_random_set(count);
        end
        s_valid <= 1'b0;

        // The checker's counts are registered at the edge, so step once before
        // looking at what is still owed.
        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d records in %0d data sets; %0d sorted entries compared.",
                 records_sent, sets_sent, entries_checked);
        $display("%0d data sets overflowed the %0d-entry store.", overflow_runs, DEPTH);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
